// ----- rtl/pbt_pkg.sv -----
// Package for the basic-regex tokenizer: token kinds, scan modes, error codes,
// character constants and the result record. No dependencies.
`timescale 1ns / 1ps
package pbt_pkg;
	localparam int CP_W = 21;
	localparam int BOUND_W = 16;
	localparam int BOUND_WIDTH = 16;
	localparam int MAX_RES = 3;
	localparam int QD = 8;
	localparam int QD_AW = $clog2(QD);
	localparam int QD_CW = $clog2(QD + 1);

	typedef logic [CP_W-1:0] cp_t;
	typedef logic [BOUND_W-1:0] bound_t;

	localparam logic [4:0] TK_CHAR = 5'd0;
	localparam logic [4:0] TK_OPEN = 5'd1;
	localparam logic [4:0] TK_CLOSE = 5'd2;
	localparam logic [4:0] TK_CARET = 5'd3;
	localparam logic [4:0] TK_RANGE = 5'd4;
	localparam logic [4:0] TK_COLL = 5'd5;
	localparam logic [4:0] TK_CLASS = 5'd6;
	localparam logic [4:0] TK_EQUIV = 5'd7;
	localparam logic [4:0] TK_GOPEN = 5'd8;
	localparam logic [4:0] TK_GCLOSE = 5'd9;
	localparam logic [4:0] TK_STAR = 5'd10;
	localparam logic [4:0] TK_PLUS = 5'd11;
	localparam logic [4:0] TK_QMARK = 5'd12;
	localparam logic [4:0] TK_ATLEAST = 5'd13;
	localparam logic [4:0] TK_ATMOST = 5'd14;
	localparam logic [4:0] TK_BETWEEN = 5'd15;
	localparam logic [4:0] TK_UNION = 5'd16;
	localparam logic [4:0] TK_BACKREF = 5'd17;
	localparam logic [4:0] TK_DOT = 5'd18;
	localparam logic [4:0] TK_BOL = 5'd19;
	localparam logic [4:0] TK_EOL = 5'd20;

	localparam logic [3:0] ERR_NONE = 4'd0;
	localparam logic [3:0] ERR_UNT_COLL = 4'd1;
	localparam logic [3:0] ERR_UNT_CLASS = 4'd2;
	localparam logic [3:0] ERR_UNT_EQUIV = 4'd3;
	localparam logic [3:0] ERR_EMPTY = 4'd4;
	localparam logic [3:0] ERR_COMMA = 4'd5;
	localparam logic [3:0] ERR_NOCLOSE = 4'd6;
	localparam logic [3:0] ERR_NOBOUND = 4'd7;
	localparam logic [3:0] ERR_TRUNC = 4'd8;

	typedef enum logic [11:0] {
		M_NORMAL = 12'b0000_0000_0001, M_ESCAPE = 12'b0000_0000_0010,
		M_INT_LOW = 12'b0000_0000_0100, M_INT_HIGH = 12'b0000_0000_1000,
		M_INT_CLOSE = 12'b0000_0001_0000, M_BR_START = 12'b0000_0010_0000,
		M_BR_CARET = 12'b0000_0100_0000, M_BR_BODY = 12'b0000_1000_0000,
		M_BR_RANGE = 12'b0001_0000_0000, M_NAME_COLL = 12'b0010_0000_0000,
		M_NAME_CLASS = 12'b0100_0000_0000, M_NAME_EQUIV = 12'b1000_0000_0000
	} mode_t;

	localparam cp_t C_LBRK = 21'h5B;
	localparam cp_t C_RBRK = 21'h5D;
	localparam cp_t C_BSL = 21'h5C;
	localparam cp_t C_DOT = 21'h2E;
	localparam cp_t C_STAR = 21'h2A;
	localparam cp_t C_CARET = 21'h5E;
	localparam cp_t C_DOLLAR = 21'h24;
	localparam cp_t C_PIPE = 21'h7C;
	localparam cp_t C_LPAR = 21'h28;
	localparam cp_t C_RPAR = 21'h29;
	localparam cp_t C_LBRACE = 21'h7B;
	localparam cp_t C_RBRACE = 21'h7D;
	localparam cp_t C_QMARK = 21'h3F;
	localparam cp_t C_PLUS = 21'h2B;
	localparam cp_t C_COMMA = 21'h2C;
	localparam cp_t C_COLON = 21'h3A;
	localparam cp_t C_EQ = 21'h3D;
	localparam cp_t C_MINUS = 21'h2D;
	localparam cp_t C_ZERO = 21'h30;
	localparam cp_t C_ONE = 21'h31;
	localparam cp_t C_NINE = 21'h39;

	typedef struct packed {
		logic [4:0] token_kind;
		cp_t char_value;
		logic name_end;
		bound_t lower_bound;
		bound_t upper_bound;
		logic [3:0] error_code;
		logic last_token;
	} res_t;

	typedef struct packed {
		logic [1:0] count;
		res_t [MAX_RES-1:0] res;
	} res_set_t;
endpackage

// ----- rtl/pbt_if.sv -----
// Valid/ready channel interfaces: one for pattern characters, one for tokens.
// Depends on pbt_pkg.
`timescale 1ns / 1ps
interface pbt_in_if;
	logic valid;
	logic ready;
	pbt_pkg::cp_t code_point;
	logic last_char;
	modport source (output valid, code_point, last_char, input ready);
	modport sink (input valid, code_point, last_char, output ready);
endinterface

interface pbt_out_if;
	logic valid;
	logic ready;
	pbt_pkg::res_t tok;
	modport source (output valid, tok, input ready);
	modport sink (input valid, tok, output ready);
endinterface

// ----- rtl/pbt_core.sv -----
// Next-state and result logic for one pattern character.
// Depends on pbt_pkg.
`timescale 1ns / 1ps
module pbt_core (
	input pbt_pkg::cp_t c,
	input logic last,
	input pbt_pkg::mode_t mode_q,
	input logic bopen_q,
	input pbt_pkg::cp_t [2:0] hist_q,
	input pbt_pkg::cp_t [1:0] held_q,
	input logic [1:0] hcnt_q,
	input logic [1:0] pos_q,
	input pbt_pkg::bound_t lo_q,
	input pbt_pkg::bound_t hi_q,
	input logic [1:0] bf_q,
	input logic [3:0] elatch_q,
	output pbt_pkg::mode_t mode_d,
	output logic bopen_d,
	output pbt_pkg::cp_t [2:0] hist_d,
	output pbt_pkg::cp_t [1:0] held_d,
	output logic [1:0] hcnt_d,
	output logic [1:0] pos_d,
	output pbt_pkg::bound_t lo_d,
	output pbt_pkg::bound_t hi_d,
	output logic [1:0] bf_d,
	output logic [3:0] elatch_d,
	output pbt_pkg::res_set_t rs
);
	import pbt_pkg::*;

	function automatic bound_t acc(bound_t a, logic [3:0] d);
		logic [BOUND_W+4:0] t;
		begin
			t = {5'd0, a} * (BOUND_W+5)'(10) + (BOUND_W+5)'(d);
			acc = (t > (BOUND_W+5)'({BOUND_W{1'b1}})) ? {BOUND_W{1'b1}} : t[BOUND_W-1:0];
		end
	endfunction

	res_t r [MAX_RES];
	logic [1:0] n;
	logic [3:0] err;
	mode_t m;
	logic bo;
	cp_t [1:0] hd;
	logic [1:0] hc;
	bound_t lo, hi;
	logic [1:0] bf;
	logic normal;
	logic isd, lit;
	logic [4:0] nk;
	cp_t dl, x;
	res_t z;

	always_comb begin
		z = '0;
		for (int i = 0; i < MAX_RES; i++) r[i] = z;
		n = 2'd0;
		err = ERR_NONE;
		m = mode_q; bo = bopen_q; hd = held_q; hc = hcnt_q;
		lo = lo_q; hi = hi_q; bf = bf_q;
		normal = 1'b0; lit = 1'b0;
		isd = (c >= C_ZERO) && (c <= C_NINE);
		nk = TK_EQUIV; dl = C_EQ; x = held_q[0];
		unique case (mode_q)
			M_NORMAL: begin
				normal = 1'b1;
				if (hcnt_q != 2'd0) begin
					if (c == C_BSL) begin
						m = M_ESCAPE; normal = 1'b0;
					end else begin
						r[0].char_value = C_DOLLAR; n = 2'd1; hc = 2'd0;
					end
				end
			end
			M_ESCAPE: begin
				m = M_NORMAL;
				if (hcnt_q != 2'd0) begin
					if (c == C_RPAR || c == C_PIPE) r[0].token_kind = TK_EOL;
					else r[0].char_value = C_DOLLAR;
					n = 2'd1; hc = 2'd0;
				end
				if (c == C_LBRACE) begin
					m = M_INT_LOW; lo = '0; hi = '0; bf = 2'd0;
				end else begin
					r[n] = z;
					if (c == C_LPAR) r[n].token_kind = TK_GOPEN;
					else if (c == C_RPAR) r[n].token_kind = TK_GCLOSE;
					else if (c == C_QMARK) r[n].token_kind = TK_QMARK;
					else if (c == C_PLUS) r[n].token_kind = TK_PLUS;
					else if (c == C_STAR) r[n].token_kind = TK_STAR;
					else if (c == C_PIPE) r[n].token_kind = TK_UNION;
					else if (c >= C_ONE && c <= C_NINE) begin
						r[n].token_kind = TK_BACKREF; r[n].char_value = c - C_ZERO;
					end else r[n].char_value = c;
					n = n + 2'd1;
				end
			end
			M_INT_LOW: begin
				if (isd) begin
					lo = acc(lo_q, c[3:0]); bf[0] = 1'b1;
				end else if (c == C_COMMA) m = M_INT_HIGH;
				else err = ERR_COMMA;
			end
			M_INT_HIGH: begin
				if (isd) begin
					hi = acc(hi_q, c[3:0]); bf[1] = 1'b1;
				end else if (c == C_BSL) m = M_INT_CLOSE;
				else err = ERR_NOCLOSE;
			end
			M_INT_CLOSE: begin
				if (c != C_RBRACE) err = ERR_NOCLOSE;
				else begin
					m = M_NORMAL;
					case (bf_q)
						2'd3: begin
							r[0].token_kind = TK_BETWEEN; r[0].lower_bound = lo_q;
							r[0].upper_bound = hi_q; n = 2'd1;
						end
						2'd1: begin
							r[0].token_kind = TK_ATLEAST; r[0].lower_bound = lo_q; n = 2'd1;
						end
						2'd2: begin
							r[0].token_kind = TK_ATMOST; r[0].upper_bound = hi_q; n = 2'd1;
						end
						default: err = ERR_NOBOUND;
					endcase
				end
			end
			M_BR_START, M_BR_CARET, M_BR_BODY, M_BR_RANGE: begin
				logic go;
				go = 1'b1;
				if (hcnt_q != 2'd0) begin
					hc = 2'd0;
					if (held_q[0] == C_LBRK) begin
						if (c == C_DOT) begin m = M_NAME_COLL; go = 1'b0; end
						else if (c == C_COLON) begin m = M_NAME_CLASS; go = 1'b0; end
						else if (c == C_EQ) begin m = M_NAME_EQUIV; go = 1'b0; end
						else begin
							r[0].char_value = C_LBRK; n = 2'd1; m = M_BR_RANGE;
						end
					end else begin
						if (c == C_RBRK) r[0].char_value = C_MINUS;
						else r[0].token_kind = TK_RANGE;
						n = 2'd1; m = M_BR_BODY;
					end
				end
				if (go) begin
					r[n] = z;
					if (c == C_RBRK) begin
						if (m == M_BR_START || m == M_BR_CARET) begin
							r[n].char_value = C_RBRK; m = M_BR_BODY;
						end else begin
							r[n].token_kind = TK_CLOSE; m = M_NORMAL; bo = 1'b0;
						end
						n = n + 2'd1;
					end else if (c == C_CARET) begin
						if (m == M_BR_START) begin
							r[n].token_kind = TK_CARET; m = M_BR_CARET;
						end else begin
							r[n].char_value = C_CARET; m = M_BR_BODY;
						end
						n = n + 2'd1;
					end else if (c == C_LBRK) begin
						hd[0] = C_LBRK; hc = 2'd1;
					end else if (c == C_MINUS && m == M_BR_RANGE) begin
						hd[0] = C_MINUS; hc = 2'd1;
					end else begin
						r[n].char_value = c; n = n + 2'd1; m = M_BR_RANGE;
					end
				end
			end
			M_NAME_COLL, M_NAME_CLASS, M_NAME_EQUIV: begin
				if (mode_q == M_NAME_COLL) begin nk = TK_COLL; dl = C_DOT; end
				else if (mode_q == M_NAME_CLASS) begin nk = TK_CLASS; dl = C_COLON; end
				if (hcnt_q == 2'd0) begin
					hd[0] = c; hc = 2'd1;
				end else if (hcnt_q == 2'd1) begin
					if (x == dl && c == C_RBRK) err = ERR_EMPTY;
					else if (c == dl) begin hd[1] = dl; hc = 2'd2; end
					else begin
						r[0].token_kind = nk; r[0].char_value = x; n = 2'd1; hd[0] = c;
					end
				end else begin
					r[0].token_kind = nk; r[0].char_value = x; n = 2'd1;
					if (c == C_RBRK) begin
						r[0].name_end = 1'b1; hc = 2'd0;
						m = (nk == TK_COLL) ? M_BR_RANGE : M_BR_BODY;
					end else if (c == dl) hd[0] = dl;
					else begin
						r[1].token_kind = nk; r[1].char_value = dl; n = 2'd2;
						hd[0] = c; hc = 2'd1;
					end
				end
			end
			default: begin
				m = M_NORMAL; hc = 2'd0; normal = 1'b1;
			end
		endcase

		if (normal) begin
			r[n] = z;
			if (c == C_LBRK) begin
				r[n].token_kind = TK_OPEN; n = n + 2'd1; m = M_BR_START; bo = 1'b1;
			end else if (c == C_BSL) m = M_ESCAPE;
			else if (c == C_DOT) begin
				r[n].token_kind = TK_DOT; n = n + 2'd1;
			end else if (c == C_STAR) begin
				lit = (pos_q == 2'd0) || (pos_q == 2'd1 && hist_q[0] == C_CARET) ||
					(pos_q >= 2'd2 && (hist_q[0] == C_PIPE || hist_q[0] == C_LPAR) &&
					hist_q[1] == C_BSL) ||
					(pos_q == 2'd3 && (hist_q[1] == C_PIPE || hist_q[1] == C_LPAR) &&
					hist_q[2] == C_BSL && hist_q[0] == C_CARET);
				if (lit) r[n].char_value = C_STAR; else r[n].token_kind = TK_STAR;
				n = n + 2'd1;
			end else if (c == C_CARET) begin
				if (pos_q == 2'd0 || (pos_q >= 2'd2 && hist_q[1] == C_BSL &&
					(hist_q[0] == C_LPAR || hist_q[0] == C_PIPE)))
					r[n].token_kind = TK_BOL;
				else r[n].char_value = C_CARET;
				n = n + 2'd1;
			end else if (c == C_DOLLAR) begin
				hd[0] = C_DOLLAR; hc = 2'd1;
			end else begin
				r[n].char_value = c; n = n + 2'd1;
			end
		end

		if (err == ERR_NONE && last) begin
			r[n] = z;
			case (m)
				M_ESCAPE, M_INT_LOW, M_INT_HIGH: err = ERR_TRUNC;
				M_INT_CLOSE: err = ERR_NOCLOSE;
				M_NAME_COLL: err = ERR_UNT_COLL;
				M_NAME_CLASS: err = ERR_UNT_CLASS;
				M_NAME_EQUIV: err = ERR_UNT_EQUIV;
				M_NORMAL: if (hc != 2'd0) begin
					r[n].token_kind = TK_EOL; n = n + 2'd1;
				end
				default: if (hc != 2'd0) begin
					if (hd[0] == C_LBRK) r[n].char_value = C_LBRK;
					else r[n].token_kind = TK_RANGE;
					n = n + 2'd1;
				end
			endcase
		end

		if (err != ERR_NONE) begin
			for (int i = 0; i < MAX_RES; i++) r[i] = z;
			r[0].error_code = err; n = 2'd1;
		end

		if (elatch_q != ERR_NONE) n = 2'd0;
		for (int i = 0; i < MAX_RES; i++) r[i].last_token = (n == 2'(i + 1));
		rs.count = n;
		for (int i = 0; i < MAX_RES; i++) rs.res[i] = r[i];

		if (last) begin
			mode_d = M_NORMAL; bopen_d = 1'b0; hist_d = '0; held_d = '0; hcnt_d = 2'd0;
			pos_d = 2'd0; lo_d = '0; hi_d = '0; bf_d = 2'd0; elatch_d = ERR_NONE;
		end else if (elatch_q != ERR_NONE) begin
			mode_d = mode_q; bopen_d = bopen_q; hist_d = hist_q; held_d = held_q;
			hcnt_d = hcnt_q; pos_d = pos_q; lo_d = lo_q; hi_d = hi_q; bf_d = bf_q;
			elatch_d = elatch_q;
		end else begin
			mode_d = m; bopen_d = bo; held_d = hd; hcnt_d = hc;
			lo_d = lo; hi_d = hi; bf_d = bf; elatch_d = err;
			hist_d = {hist_q[1], hist_q[0], c};
			pos_d = (pos_q == 2'd3) ? pos_q : pos_q + 2'd1;
		end
	end
endmodule

// ----- rtl/posix_bre_tokenizer_top.sv -----
// Top level of the basic-regex tokenizer: input register, tokenizer state,
// result queue. Depends on pbt_pkg, pbt_if and pbt_core.
`timescale 1ns / 1ps
// Takes one pattern character per cycle while the queue has room and emits zero
// to three tokens for it, one token per cycle on the output channel while the
// receiver is ready. An accepted character is registered, decoded in the next
// cycle and its tokens enter an eight-deep queue, from which they are offered in
// order; input is taken while no more than two tokens are queued, which leaves
// room for the registered character's tokens plus a new one's. Throughput is one
// character per cycle as long as characters average no more than one token; the
// queue drain rate of one token per cycle sets the limit otherwise.
module posix_bre_tokenizer_top (
	input logic clk,
	input logic arst_n,
	pbt_in_if.sink in_ch,
	pbt_out_if.source out_ch
);
	import pbt_pkg::*;

	logic v_s1;
	cp_t c_s1;
	logic last_s1;
	mode_t mode_q, mode_d;
	logic bopen_q, bopen_d;
	cp_t [2:0] hist_q, hist_d;
	cp_t [1:0] held_q, held_d;
	logic [1:0] hcnt_q, hcnt_d, pos_q, pos_d, bf_q, bf_d;
	bound_t lo_q, lo_d, hi_q, hi_d;
	logic [3:0] elatch_q, elatch_d;
	res_set_t rs;
	res_t q_q [QD];
	logic [QD_AW-1:0] wp_q, rp_q;
	logic [QD_CW-1:0] cnt_q, cnt_d, wr_n;
	logic pop;

	pbt_core u_core (
		.c(c_s1), .last(last_s1), .mode_q(mode_q), .bopen_q(bopen_q), .hist_q(hist_q),
		.held_q(held_q), .hcnt_q(hcnt_q), .pos_q(pos_q), .lo_q(lo_q), .hi_q(hi_q),
		.bf_q(bf_q), .elatch_q(elatch_q), .mode_d(mode_d), .bopen_d(bopen_d),
		.hist_d(hist_d), .held_d(held_d), .hcnt_d(hcnt_d), .pos_d(pos_d), .lo_d(lo_d),
		.hi_d(hi_d), .bf_d(bf_d), .elatch_d(elatch_d), .rs(rs)
	);

	// room for the registered item's results plus a new one's
	assign in_ch.ready = (cnt_q <= QD_CW'(QD - 2 * MAX_RES));
	assign out_ch.valid = (cnt_q != '0);
	assign out_ch.tok = q_q[rp_q];
	assign pop = out_ch.valid && out_ch.ready;
	assign wr_n = v_s1 ? QD_CW'(rs.count) : '0;
	assign cnt_d = cnt_q + wr_n - QD_CW'(pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; mode_q <= M_NORMAL; bopen_q <= 1'b0; hist_q <= '0; held_q <= '0;
			hcnt_q <= 2'd0; pos_q <= 2'd0; lo_q <= '0; hi_q <= '0; bf_q <= 2'd0;
			elatch_q <= ERR_NONE; wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			v_s1 <= in_ch.valid && in_ch.ready;
			if (v_s1) begin
				mode_q <= mode_d; bopen_q <= bopen_d; hist_q <= hist_d; held_q <= held_d;
				hcnt_q <= hcnt_d; pos_q <= pos_d; lo_q <= lo_d; hi_q <= hi_d; bf_q <= bf_d;
				elatch_q <= elatch_d;
				wp_q <= wp_q + wr_n[QD_AW-1:0];
			end
			if (pop) rp_q <= rp_q + QD_AW'(1);
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			c_s1 <= in_ch.code_point;
			last_s1 <= in_ch.last_char;
		end
		if (v_s1) begin
			for (int i = 0; i < MAX_RES; i++)
				if (2'(i) < rs.count) q_q[wp_q + QD_AW'(i)] <= rs.res[i];
		end
	end
endmodule

// ----- rtl/pbt_checker.sv -----
// Port-level checks for the tokenizer, bound to the top level.
// Depends on pbt_pkg.
`timescale 1ns / 1ps
module pbt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input pbt_pkg::res_t tok
);
	import pbt_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tok))
		else $error("stalled token changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tok.error_code != ERR_NONE |-> tok.last_token && tok.token_kind == TK_CHAR)
		else $error("error token malformed");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tok.token_kind > TK_EOL |-> 1'b0)
		else $error("bad token kind");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tok.name_end |-> tok.token_kind == TK_COLL ||
		tok.token_kind == TK_CLASS || tok.token_kind == TK_EQUIV)
		else $error("name end on non-name token");
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request refused with empty queue");
endmodule

bind posix_bre_tokenizer_top pbt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .tok(out_ch.tok)
);

// ----- sim/posix_bre_tokenizer_top_tb.sv -----
// Testbench for the basic-regex tokenizer: directed and random patterns driven
// through the request channel, tokens predicted in-bench and compared in order.
// Depends on pbt_pkg, pbt_if and posix_bre_tokenizer_top.
`timescale 1ns / 1ps
module posix_bre_tokenizer_top_tb;
	import pbt_pkg::*;

	typedef struct {
		cp_t cp;
		logic last;
	} req_t;

	logic clk;
	logic arst_n;
	pbt_in_if in_ch ();
	pbt_out_if out_ch ();

	posix_bre_tokenizer_top dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	// tokenizer shadow state
	logic br_open;
	mode_t mode;
	cp_t hist [3];
	cp_t held [2];
	int unsigned held_n;
	int unsigned pos;
	longint unsigned lo_acc, hi_acc;
	logic [1:0] bflags;
	logic [3:0] err_latch;
	logic [3:0] step_err;
	res_t step_toks [$];

	req_t pending [$];
	res_t tokens_due [$];
	int unsigned n_bad;
	int unsigned in_gap, out_gap;
	bit quiet;
	bit hold_off;
	bit all_sent;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic void clear_state();
		br_open = 0; mode = M_NORMAL;
		hist[0] = 0; hist[1] = 0; hist[2] = 0;
		held[0] = 0; held[1] = 0; held_n = 0; pos = 0;
		lo_acc = 0; hi_acc = 0; bflags = 0; err_latch = ERR_NONE;
	endfunction

	function automatic void put_tok(logic [4:0] k, cp_t v, logic ne, longint unsigned lb,
			longint unsigned ub, logic [3:0] e);
		res_t r;
		if (step_toks.size() >= MAX_RES) return;
		r.token_kind = k; r.char_value = v; r.name_end = ne;
		r.lower_bound = lb[15:0]; r.upper_bound = ub[15:0];
		r.error_code = e; r.last_token = 0;
		step_toks.insert(step_toks.size(), r);
	endfunction

	function automatic void put(logic [4:0] k, cp_t v);
		put_tok(k, v, 0, 0, 0, ERR_NONE);
	endfunction

	function automatic void flag(logic [3:0] e);
		if (step_err == ERR_NONE) step_err = e;
	endfunction

	function automatic longint unsigned accum(longint unsigned a, cp_t d);
		longint unsigned mx;
		mx = (64'd1 << BOUND_WIDTH) - 1;
		a = a * 10 + d;
		return a > mx ? mx : a;
	endfunction

	function automatic void scan_normal(cp_t c);
		bit lit;
		if (c == C_LBRK) begin
			put(TK_OPEN, 0); mode = M_BR_START; br_open = 1;
		end else if (c == C_BSL) begin
			mode = M_ESCAPE;
		end else if (c == C_DOT) begin
			put(TK_DOT, 0);
		end else if (c == C_STAR) begin
			lit = pos == 0 || (pos == 1 && hist[0] == C_CARET) ||
				(pos >= 2 && (hist[0] == C_PIPE || hist[0] == C_LPAR) && hist[1] == C_BSL) ||
				(pos >= 3 && (hist[1] == C_PIPE || hist[1] == C_LPAR) && hist[2] == C_BSL &&
				hist[0] == C_CARET);
			if (lit) put(TK_CHAR, C_STAR); else put(TK_STAR, 0);
		end else if (c == C_CARET) begin
			if (pos == 0 || (pos >= 2 && hist[1] == C_BSL &&
					(hist[0] == C_LPAR || hist[0] == C_PIPE)))
				put(TK_BOL, 0);
			else
				put(TK_CHAR, C_CARET);
		end else if (c == C_DOLLAR) begin
			held[0] = C_DOLLAR; held_n = 1;
		end else begin
			put(TK_CHAR, c);
		end
	endfunction

	function automatic void scan_escape(cp_t c);
		mode = M_NORMAL;
		if (held_n != 0) begin
			if (c == C_RPAR || c == C_PIPE) put(TK_EOL, 0); else put(TK_CHAR, C_DOLLAR);
			held_n = 0;
		end
		case (c)
			C_LPAR: put(TK_GOPEN, 0);
			C_RPAR: put(TK_GCLOSE, 0);
			C_LBRACE: begin
				mode = M_INT_LOW; lo_acc = 0; hi_acc = 0; bflags = 0;
			end
			C_QMARK: put(TK_QMARK, 0);
			C_PLUS: put(TK_PLUS, 0);
			C_STAR: put(TK_STAR, 0);
			C_PIPE: put(TK_UNION, 0);
			default: begin
				if (c >= C_ONE && c <= C_NINE) put(TK_BACKREF, c - C_ZERO);
				else put(TK_CHAR, c);
			end
		endcase
	endfunction

	function automatic void scan_interval(cp_t c);
		bit dig;
		dig = c >= C_ZERO && c <= C_NINE;
		if (mode == M_INT_LOW) begin
			if (dig) begin
				lo_acc = accum(lo_acc, c - C_ZERO); bflags[0] = 1;
			end else if (c == C_COMMA) mode = M_INT_HIGH;
			else flag(ERR_COMMA);
		end else if (mode == M_INT_HIGH) begin
			if (dig) begin
				hi_acc = accum(hi_acc, c - C_ZERO); bflags[1] = 1;
			end else if (c == C_BSL) mode = M_INT_CLOSE;
			else flag(ERR_NOCLOSE);
		end else begin
			if (c != C_RBRACE) begin
				flag(ERR_NOCLOSE);
				return;
			end
			mode = M_NORMAL;
			case (bflags)
				2'b11: put_tok(TK_BETWEEN, 0, 0, lo_acc, hi_acc, ERR_NONE);
				2'b01: put_tok(TK_ATLEAST, 0, 0, lo_acc, 0, ERR_NONE);
				2'b10: put_tok(TK_ATMOST, 0, 0, 0, hi_acc, ERR_NONE);
				default: flag(ERR_NOBOUND);
			endcase
		end
	endfunction

	function automatic void scan_bracket(cp_t c);
		if (c == C_RBRK) begin
			if (mode == M_BR_START || mode == M_BR_CARET) begin
				put(TK_CHAR, C_RBRK); mode = M_BR_BODY;
			end else begin
				put(TK_CLOSE, 0); mode = M_NORMAL; br_open = 0;
			end
		end else if (c == C_CARET) begin
			if (mode == M_BR_START) begin
				put(TK_CARET, 0); mode = M_BR_CARET;
			end else begin
				put(TK_CHAR, C_CARET); mode = M_BR_BODY;
			end
		end else if (c == C_LBRK) begin
			held[0] = C_LBRK; held_n = 1;
		end else if (c == C_MINUS && mode == M_BR_RANGE) begin
			held[0] = C_MINUS; held_n = 1;
		end else begin
			put(TK_CHAR, c); mode = M_BR_RANGE;
		end
	endfunction

	function automatic void scan_bracket_held(cp_t c);
		if (held_n != 0) begin
			held_n = 0;
			if (held[0] == C_LBRK) begin
				if (c == C_DOT) begin mode = M_NAME_COLL; return; end
				if (c == C_COLON) begin mode = M_NAME_CLASS; return; end
				if (c == C_EQ) begin mode = M_NAME_EQUIV; return; end
				put(TK_CHAR, C_LBRK); mode = M_BR_RANGE;
			end else begin
				if (c == C_RBRK) put(TK_CHAR, C_MINUS); else put(TK_RANGE, 0);
				mode = M_BR_BODY;
			end
		end
		scan_bracket(c);
	endfunction

	function automatic void scan_name(cp_t c);
		logic [4:0] k;
		cp_t d, x;
		k = mode == M_NAME_COLL ? TK_COLL : (mode == M_NAME_CLASS ? TK_CLASS : TK_EQUIV);
		d = k == TK_COLL ? C_DOT : (k == TK_CLASS ? C_COLON : C_EQ);
		x = held[0];
		if (held_n == 0) begin
			held[0] = c; held_n = 1;
		end else if (held_n == 1) begin
			if (x == d && c == C_RBRK) flag(ERR_EMPTY);
			else if (c == d) begin
				held[1] = d; held_n = 2;
			end else begin
				put(k, x); held[0] = c;
			end
		end else begin
			if (c == C_RBRK) begin
				put_tok(k, x, 1, 0, 0, ERR_NONE); held_n = 0;
				mode = k == TK_COLL ? M_BR_RANGE : M_BR_BODY;
			end else if (c == d) begin
				put(k, x); held[0] = d;
			end else begin
				put(k, x); put(k, d); held[0] = c; held_n = 1;
			end
		end
	endfunction

	function automatic void scan_end();
		case (mode)
			M_ESCAPE, M_INT_LOW, M_INT_HIGH: flag(ERR_TRUNC);
			M_INT_CLOSE: flag(ERR_NOCLOSE);
			M_NAME_COLL: flag(ERR_UNT_COLL);
			M_NAME_CLASS: flag(ERR_UNT_CLASS);
			M_NAME_EQUIV: flag(ERR_UNT_EQUIV);
			M_NORMAL: if (held_n != 0) put(TK_EOL, 0);
			default: if (held_n != 0) begin
				if (held[0] == C_LBRK) put(TK_CHAR, C_LBRK); else put(TK_RANGE, 0);
			end
		endcase
	endfunction

	function automatic void tokenize(cp_t c, logic last);
		if (err_latch != ERR_NONE) begin
			if (last) clear_state();
			return;
		end
		step_toks.delete();
		step_err = ERR_NONE;
		case (mode)
			M_NORMAL: begin
				if (held_n != 0 && c == C_BSL) mode = M_ESCAPE;
				else begin
					if (held_n != 0) begin
						put(TK_CHAR, C_DOLLAR); held_n = 0;
					end
					scan_normal(c);
				end
			end
			M_ESCAPE: scan_escape(c);
			M_INT_LOW, M_INT_HIGH, M_INT_CLOSE: scan_interval(c);
			M_BR_START, M_BR_CARET, M_BR_BODY, M_BR_RANGE: scan_bracket_held(c);
			M_NAME_COLL, M_NAME_CLASS, M_NAME_EQUIV: scan_name(c);
			default: begin
				mode = M_NORMAL; held_n = 0; scan_normal(c);
			end
		endcase
		if (step_err == ERR_NONE && last) scan_end();
		if (step_err != ERR_NONE) begin
			step_toks.delete();
			put_tok(TK_CHAR, 0, 0, 0, 0, step_err);
			err_latch = step_err;
		end
		hist[2] = hist[1]; hist[1] = hist[0]; hist[0] = c;
		if (pos < 3) pos++;
		if (last) clear_state();
		if (step_toks.size() > 0) step_toks[step_toks.size()-1].last_token = 1;
		foreach (step_toks[i]) tokens_due.insert(tokens_due.size(), step_toks[i]);
	endfunction

	function automatic void add(cp_t c, logic last);
		req_t r;
		r.cp = c; r.last = last;
		pending.insert(pending.size(), r);
	endfunction

	function automatic void add_str(string s);
		for (int i = 0; i < s.len(); i++) add(cp_t'(s[i]), i == s.len() - 1);
	endfunction

	function automatic cp_t pick_char();
		case ($urandom_range(0, 9))
			0: return cp_t'($urandom_range(0, 21'h1FFFFF));
			1: return cp_t'($urandom_range(21'h80, 21'h10FFFF));
			2, 3: return cp_t'($urandom_range(C_ZERO, C_NINE));
			default: begin
				string syms;
				syms = "[]\\.*^$|(){}?+,:=-ab";
				return cp_t'(syms[$urandom_range(0, syms.len() - 1)]);
			end
		endcase
	endfunction

	function automatic void add_pattern();
		string p;
		int n;
		case ($urandom_range(0, 7))
			0: p = "^a*\\(b\\|c\\)$";
			1: p = {"x\\{", $sformatf("%0d", $urandom_range(0, 99999)), ",",
				$sformatf("%0d", $urandom_range(0, 999)), "\\}"};
			2: p = "[^]a-z[.-.][:alpha:][=e=]-]";
			3: p = "[[.ab.]-c]\\1\\9.";
			4: p = "\\(*^*\\)\\|$\\)";
			5: p = "[a[b[:x:y:]]";
			6: p = "\\{,7\\}\\{3\\}";
			default: p = "";
		endcase
		n = p.len();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) add(pick_char(), 0);
			else add(cp_t'(p[i]), 0);
		end
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++) add(pick_char(), 0);
		add(pick_char(), 1);
	endfunction

	initial begin
		arst_n = 1'b0;
		clear_state();
		n_bad = 0; in_gap = 0; out_gap = 0; quiet = 0; hold_off = 0; all_sent = 0;
		add(21'h1FFFFF, 0); add(21'h10FFFF, 0); add(0, 1);
		add_str("^*a.b*\\(^*x\\)\\|c$");
		add_str("a$b$\\|\\{2,\\}\\{,65536\\}");
		add_str("\\{99999999,3\\}\\+\\?\\*\\5\\q$");
		add_str("[^]a-][-b-]");
		add_str("[[.-.]-z[:alpha:][=a=][a[x]");
		add_str("[[..]]"); add_str("a\\{b"); add_str("\\{1,x"); add_str("\\{1,2\\x");
		add_str("\\{,\\}"); add_str("\\"); add_str("\\{3,4\\"); add_str("[[.ab");
		add_str("[[:ab:"); add_str("[[=a="); add_str("[a-"); add_str("[[");
		add_str("$"); add_str("\\($\\)");
		while (pending.size() < 370) add_pattern();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.code_point <= '0;
			in_ch.last_char <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				tokenize(in_ch.code_point, in_ch.last_char);
				void'(pending.pop_front());
			end
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_ch.valid <= 1'b0;
			end else if (!(in_ch.valid && !in_ch.ready) &&
					!quiet && $urandom_range(0, 11) == 0) begin
				in_gap <= $urandom_range(0, 13);
				in_ch.valid <= 1'b0;
			end else if (pending.size() > 0) begin
				in_ch.code_point <= pending[0].cp;
				in_ch.last_char <= pending[0].last;
				in_ch.valid <= 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off
	initial begin
		wait (arst_n);
		repeat (60) @(posedge clk);
		hold_off = 1;
		repeat (200) @(posedge clk);
		hold_off = 0;
	end

	// token monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (tokens_due.size() == 0) begin
					n_bad++;
					if (n_bad <= 10) $display("unexpected token %p", out_ch.tok);
				end else begin
					if (out_ch.tok !== tokens_due[0]) begin
						n_bad++;
						if (n_bad <= 10)
							$display("token mismatch: expected %p actual %p",
								tokens_due[0], out_ch.tok);
					end
					void'(tokens_due.pop_front());
				end
			end
			if (hold_off) begin
				out_ch.ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				out_gap <= $urandom_range(0, 13);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		wait (arst_n);
		wait (pending.size() < 60);
		quiet = 1;
		wait (pending.size() == 0);
		wait (tokens_due.size() == 0);
		repeat (20) @(posedge clk);
		if (n_bad == 0 && tokens_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
